@@ hw/rtl/waveform_window_statistics_top_defines.svh @@
// Assertion macros for the window statistics block.
// Used by the controller and the top level; no other dependencies.
`ifndef WAVEFORM_WINDOW_STATISTICS_TOP_DEFINES_SVH
`define WAVEFORM_WINDOW_STATISTICS_TOP_DEFINES_SVH

// Implication checked on every edge outside reset.
`define WWS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define WWS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hw/rtl/wws_pkg.sv @@
// Shared types, constants and command structs for the window statistics block.
// No dependencies.
package wws_pkg;

    localparam int MaxSamples = 4096;
    localparam int TallyW     = 13;
    localparam int SqW        = 43;
    localparam int LvlW       = 29;
    localparam int SumW       = 28;
    localparam int DivW       = 43;   // widest dividend
    localparam int DivCntW    = 6;
    localparam int SqrtCntW   = 5;

    localparam logic [1:0] PhaseA = 2'd0;
    localparam logic [1:0] PhaseB = 2'd1;

    localparam logic [1:0] RegPhase  = 2'd0;
    localparam logic [1:0] RegClip   = 2'd1;
    localparam logic [1:0] RegRmsLow = 2'd2;
    localparam logic [1:0] RegRmsHi  = 2'd3;

    // Divide job selector, in the order the controller runs them.
    typedef enum logic [2:0] {
        JOB_SQ   = 3'd0,
        JOB_LVL  = 3'd1,
        JOB_FRQ  = 3'd2,
        JOB_PF   = 3'd3,
        JOB_THD  = 3'd4
    } job_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_START,
        ST_DIV_RUN,
        ST_SQRT_RUN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic  snap;        // capture window totals, clear accumulators
        logic  div_start;   // load divider with job
        job_t  job;
        logic  div_step;
        logic  div_store;   // store quotient for job
        logic  sqrt_start;
        logic  sqrt_step;
        logic  out_load;    // fill output register
    } cmd_t;

    typedef struct packed {
        logic div_last;
        logic sqrt_last;
    } stat_t;

endpackage

@@ hw/rtl/waveform_window_statistics_top.sv @@
// Top level of the window statistics block: APB registers, handshake, units.
// Depends on wws_pkg, wws_ctrl, wws_datapath and the assertion macro header.
//
//  channel  direction  handshake           payload
//  in       sink       in_valid/in_stall   phase_a_volts .. last_sample
//  out      source     out_valid/out_stall rms_volts .. mean_distortion
//  cfg      APB slave  psel/penable/pready 4 regs at 4*i
//
// Samples are taken one per cycle while a window accumulates. The closing
// beat starts five 43-step restoring divides (each after a load state), a
// 16-step square root and an output load, during all of which input
// stalls; the stall lasts longer while the output register is still held
// by the receiver. The next window then accumulates while the result waits
// in the output register. Reset clears the accumulators, controller state
// and out_valid, sets the config registers; other data is not reset.
`include "waveform_window_statistics_top_defines.svh"
module waveform_window_statistics_top
    import wws_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic        [3:0]  paddr,
    input  logic        [31:0] pwdata,
    output logic        [31:0] prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] phase_a_volts,
    input  logic signed [15:0] phase_b_volts,
    input  logic signed [15:0] phase_c_volts,
    input  logic        [15:0] line_frequency,
    input  logic signed [15:0] power_factor_in,
    input  logic        [15:0] distortion_percent,
    input  logic               last_sample,
    output logic               out_valid,
    input  logic               out_stall,
    output logic        [15:0] rms_volts,
    output logic        [15:0] peak_to_peak,
    output logic signed [15:0] dc_mean,
    output logic        [12:0] clipped_count,
    output logic               compliant,
    output logic        [15:0] mean_frequency,
    output logic signed [15:0] mean_power_factor,
    output logic        [15:0] mean_distortion
);

    logic [1:0]  phase_reg;
    logic [14:0] clip_reg, low_reg, high_reg;
    logic        wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 2'd0;
            clip_reg  <= 15'd20794;
            low_reg   <= 15'd13248;
            high_reg  <= 15'd16192;
        end
        else if (wr && paddr[1:0] == 2'b00)
        begin
            unique case (paddr[3:2])
                RegPhase:  phase_reg <= pwdata[1:0];
                RegClip:   clip_reg  <= pwdata[14:0];
                RegRmsLow: low_reg   <= pwdata[14:0];
                default:   high_reg  <= pwdata[14:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            RegPhase:  prdata = {30'd0, phase_reg};
            RegClip:   prdata = {17'd0, clip_reg};
            RegRmsLow: prdata = {17'd0, low_reg};
            default:   prdata = {17'd0, high_reg};
        endcase
    end

    // handshake
    logic  busy, accept, window_end, close, out_take;
    cmd_t  cmd;
    stat_t stat;

    assign in_stall = busy;
    assign accept   = in_valid && !in_stall;
    assign close    = accept && (last_sample || window_end);
    assign out_take = out_valid && !out_stall;

    wws_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .close    (close),
        .out_free (!out_valid || out_take),
        .stat     (stat),
        .busy     (busy),
        .cmd      (cmd)
    );

    wws_datapath u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .accept             (accept),
        .phase_a_volts      (phase_a_volts),
        .phase_b_volts      (phase_b_volts),
        .phase_c_volts      (phase_c_volts),
        .line_frequency     (line_frequency),
        .power_factor_in    (power_factor_in),
        .distortion_percent (distortion_percent),
        .phase_select       (phase_reg),
        .clip_level         (clip_reg),
        .rms_low_limit      (low_reg),
        .rms_high_limit     (high_reg),
        .out_take           (out_take),
        .cmd                (cmd),
        .stat               (stat),
        .window_end         (window_end),
        .out_valid          (out_valid),
        .rms_volts          (rms_volts),
        .peak_to_peak       (peak_to_peak),
        .dc_mean            (dc_mean),
        .clipped_count      (clipped_count),
        .compliant          (compliant),
        .mean_frequency     (mean_frequency),
        .mean_power_factor  (mean_power_factor),
        .mean_distortion    (mean_distortion)
    );

    `WWS_ASSERT_IMP(a_out_hold, clk, rst_n, out_valid && out_stall, !cmd.out_load)
    `WWS_ASSERT_NEXT(a_close_stalls, clk, rst_n, close, in_stall)
    `WWS_ASSERT_IMP(a_stall_busy, clk, rst_n, in_stall, busy)

endmodule

@@ hw/rtl/wws_ctrl.sv @@
// Controller for window close: sequences five divides, the square root and the output load.
// Depends on wws_pkg and the assertion macro header.
`include "waveform_window_statistics_top_defines.svh"
module wws_ctrl
    import wws_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  close,       // closing beat accepted
    input  logic  out_free,    // output register empty or draining
    input  stat_t stat,
    output logic  busy,
    output cmd_t  cmd
);

    state_t state_reg, state_next;
    job_t   job_reg, job_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            job_reg   <= JOB_SQ;
        end
        else
        begin
            state_reg <= state_next;
            job_reg   <= job_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        cmd            = '0;
        cmd.job        = job_reg;
        cmd.snap       = close;
        busy           = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (close)
                begin
                    state_next = ST_DIV_START;
                    job_next   = JOB_SQ;
                end
            end
            ST_DIV_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_RUN;
            end
            ST_DIV_RUN:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    cmd.div_store = 1'b1;
                    unique case (job_reg)
                        JOB_SQ:  begin job_next = JOB_LVL; state_next = ST_DIV_START; end
                        JOB_LVL: begin job_next = JOB_FRQ; state_next = ST_DIV_START; end
                        JOB_FRQ: begin job_next = JOB_PF;  state_next = ST_DIV_START; end
                        JOB_PF:  begin job_next = JOB_THD; state_next = ST_DIV_START; end
                        default: state_next = ST_SQRT_RUN;
                    endcase
                    if (job_reg == JOB_THD)
                        cmd.sqrt_start = 1'b1;
                end
            end
            ST_SQRT_RUN:
            begin
                cmd.sqrt_step = 1'b1;
                if (stat.sqrt_last)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    `WWS_ASSERT_IMP(a_no_close_busy, clk, rst_n, busy, !close)
    `WWS_ASSERT_NEXT(a_close_starts, clk, rst_n, close, state_reg == ST_DIV_START)
    `WWS_ASSERT_IMP(a_store_in_run, clk, rst_n, cmd.div_store, state_reg == ST_DIV_RUN)

endmodule

@@ hw/rtl/wws_datapath.sv @@
// Accumulators, restoring divider, bit-pair square root and result register.
// Depends on wws_pkg.
module wws_datapath
    import wws_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic signed [15:0] phase_a_volts,
    input  logic signed [15:0] phase_b_volts,
    input  logic signed [15:0] phase_c_volts,
    input  logic        [15:0] line_frequency,
    input  logic signed [15:0] power_factor_in,
    input  logic        [15:0] distortion_percent,
    input  logic        [1:0]  phase_select,
    input  logic        [14:0] clip_level,
    input  logic        [14:0] rms_low_limit,
    input  logic        [14:0] rms_high_limit,
    input  logic               out_take,
    input  cmd_t               cmd,
    output stat_t              stat,
    output logic               window_end,
    output logic               out_valid,
    output logic        [15:0] rms_volts,
    output logic        [15:0] peak_to_peak,
    output logic signed [15:0] dc_mean,
    output logic        [12:0] clipped_count,
    output logic               compliant,
    output logic        [15:0] mean_frequency,
    output logic signed [15:0] mean_power_factor,
    output logic        [15:0] mean_distortion
);

    // ---- accumulation ----
    logic        [SqW-1:0]    sq_reg;
    logic signed [LvlW-1:0]   lvl_reg;
    logic signed [15:0]       min_reg, max_reg;
    logic        [TallyW-1:0] clip_reg, cnt_reg;
    logic        [SumW-1:0]   frq_reg, thd_reg;
    logic signed [SumW-1:0]   pf_reg;

    logic signed [15:0] v;
    logic        [16:0] mag;
    logic        [31:0] vsq;
    logic        [TallyW-1:0] cnt_inc;

    always_comb
    begin
        unique case (phase_select)
            PhaseA:  v = phase_a_volts;
            PhaseB:  v = phase_b_volts;
            default: v = phase_c_volts;
        endcase
        mag        = v[15] ? 17'(-$signed({v[15], v})) : {1'b0, v};
        vsq        = 32'($signed(v) * $signed(v));
        cnt_inc    = cnt_reg + TallyW'(1);
        // this beat is the last one a full window can hold
        window_end = (cnt_reg == TallyW'(MaxSamples - 1));
    end

    // window totals captured at close
    logic        [SqW-1:0]    t_sq;
    logic        [LvlW-1:0]   t_lvl;
    logic        [SumW-1:0]   t_frq, t_pf, t_thd;
    logic        [TallyW:0]   t_n;
    logic        [15:0]       t_p2p;
    logic        [TallyW-1:0] t_clip;

    logic        [SqW-1:0]    sq_n;
    logic signed [LvlW-1:0]   lvl_n;
    logic signed [15:0]       min_n, max_n;
    logic        [TallyW-1:0] clip_n;
    logic        [SumW-1:0]   frq_n, thd_n;
    logic signed [SumW-1:0]   pf_n;

    always_comb
    begin
        sq_n   = sq_reg + SqW'(vsq);
        lvl_n  = lvl_reg + LvlW'(v);
        frq_n  = frq_reg + SumW'(line_frequency);
        thd_n  = thd_reg + SumW'(distortion_percent);
        pf_n   = pf_reg + SumW'(power_factor_in);
        clip_n = clip_reg + TallyW'(mag >= {2'b0, clip_level});
        min_n  = (cnt_reg == '0 || v < min_reg) ? v : min_reg;
        max_n  = (cnt_reg == '0 || v > max_reg) ? v : max_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            sq_reg  <= '0;
            lvl_reg <= '0;
            clip_reg <= '0;
            frq_reg <= '0;
            thd_reg <= '0;
            pf_reg  <= '0;
            min_reg <= '0;
            max_reg <= '0;
        end
        else if (accept)
        begin
            if (cmd.snap)
            begin
                cnt_reg <= '0; sq_reg <= '0; lvl_reg <= '0; clip_reg <= '0;
                frq_reg <= '0; thd_reg <= '0; pf_reg <= '0;
                min_reg <= '0; max_reg <= '0;
            end
            else
            begin
                cnt_reg <= cnt_inc; sq_reg <= sq_n; lvl_reg <= lvl_n; clip_reg <= clip_n;
                frq_reg <= frq_n; thd_reg <= thd_n; pf_reg <= pf_n;
                min_reg <= min_n; max_reg <= max_n;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && cmd.snap)
        begin
            t_sq   <= sq_n;
            t_lvl  <= lvl_n;
            t_frq  <= frq_n;
            t_thd  <= thd_n;
            t_pf   <= pf_n;
            t_clip <= clip_n;
            t_n    <= {1'b0, cnt_reg} + (TallyW + 1)'(1);
            t_p2p  <= 16'(max_n - min_n);
        end
    end

    // ---- restoring divider, magnitude in, sign fixed after ----
    logic [DivW-1:0]    dq_reg;    // dividend shifting into quotient
    logic [TallyW+1:0]  rem_reg;
    logic [DivCntW-1:0] dcnt_reg;
    logic               dneg_reg;
    logic [DivW-1:0]    dsrc;
    logic               dneg;
    logic [TallyW+1:0]  rem_sh, rem_sub;

    always_comb
    begin
        dneg = 1'b0;
        unique case (cmd.job)
            JOB_SQ:  dsrc = t_sq;
            JOB_LVL:
            begin
                dneg = t_lvl[LvlW-1];
                dsrc = DivW'(dneg ? LvlW'(-t_lvl) : t_lvl);
            end
            JOB_FRQ: dsrc = DivW'(t_frq);
            JOB_PF:
            begin
                dneg = t_pf[SumW-1];
                dsrc = DivW'(dneg ? SumW'(-t_pf) : t_pf);
            end
            default: dsrc = DivW'(t_thd);
        endcase
        rem_sh  = {rem_reg[TallyW:0], dq_reg[DivW-1]};
        rem_sub = rem_sh - {1'b0, t_n};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            dq_reg   <= dsrc;
            rem_reg  <= '0;
            dcnt_reg <= '0;
            dneg_reg <= dneg;
        end
        else if (cmd.div_step && !cmd.div_store)
        begin
            dcnt_reg <= dcnt_reg + DivCntW'(1);
            if (!rem_sub[TallyW+1])
            begin
                rem_reg <= rem_sub;
                dq_reg  <= {dq_reg[DivW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                dq_reg  <= {dq_reg[DivW-2:0], 1'b0};
            end
        end
    end

    // final step result, taken with div_store
    logic [DivW-1:0] qfin;
    always_comb
    begin
        qfin = {dq_reg[DivW-2:0], !rem_sub[TallyW+1]};
        if (dneg_reg)
            qfin = DivW'(-qfin);
    end

    logic [31:0] msq_reg;
    logic [15:0] dc_reg, frqm_reg, pfm_reg, thdm_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.div_store)
        begin
            unique case (cmd.job)
                JOB_SQ:  msq_reg  <= qfin[31:0];
                JOB_LVL: dc_reg   <= qfin[15:0];
                JOB_FRQ: frqm_reg <= qfin[15:0];
                JOB_PF:  pfm_reg  <= qfin[15:0];
                default: thdm_reg <= qfin[15:0];
            endcase
        end
    end

    // ---- square root, two bits per step ----
    logic [31:0] sv_reg;
    logic [17:0] srem_reg;
    logic [15:0] root_reg;
    logic [SqrtCntW-1:0] scnt_reg;
    logic [17:0] srem_sh, strial;
    logic [31:0] sv_src;

    always_comb
    begin
        // mean square was stored by the first divide
        sv_src  = cmd.sqrt_start ? msq_reg : sv_reg;
        srem_sh = {srem_reg[15:0], sv_reg[31:30]};
        strial  = {root_reg, 2'b01};
    end

    assign stat = '{div_last:  (dcnt_reg == DivCntW'(DivW - 1)),
                    sqrt_last: (scnt_reg == SqrtCntW'(15))};

    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_start)
        begin
            sv_reg   <= sv_src;
            srem_reg <= '0;
            root_reg <= '0;
            scnt_reg <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            sv_reg   <= {sv_reg[29:0], 2'b00};
            scnt_reg <= scnt_reg + SqrtCntW'(1);
            if (srem_sh >= strial)
            begin
                srem_reg <= srem_sh - strial;
                root_reg <= {root_reg[14:0], 1'b1};
            end
            else
            begin
                srem_reg <= srem_sh;
                root_reg <= {root_reg[14:0], 1'b0};
            end
        end
    end

    // ---- output register ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (cmd.out_load)
            out_valid <= 1'b1;
        else if (out_take)
            out_valid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            rms_volts         <= root_reg;
            peak_to_peak      <= t_p2p;
            dc_mean           <= dc_reg;
            clipped_count     <= t_clip;
            compliant         <= ({1'b0, rms_low_limit} <= root_reg) &&
                                 (root_reg <= {1'b0, rms_high_limit});
            mean_frequency    <= frqm_reg;
            mean_power_factor <= pfm_reg;
            mean_distortion   <= thdm_reg;
        end
    end

endmodule

@@ tb/tb_waveform_window_statistics_top.sv @@
// Self-checking testbench for waveform_window_statistics_top.
// Needs only wws_pkg and the RTL; predicts each window result and checks every output beat.
module tb_waveform_window_statistics_top;
    import wws_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SettleCycles = 300;   // settle time for a close's divides and root
    localparam int StallLimit   = 6000;  // idle cycles before the watchdog trips
    localparam int HoldCycles   = 1500;  // long receiver hold-off

    typedef struct {
        logic signed [15:0] va;
        logic signed [15:0] vb;
        logic signed [15:0] vc;
        logic        [15:0] freq;
        logic signed [15:0] pf;
        logic        [15:0] thd;
        logic               last;
    } beat_t;

    typedef struct {
        logic        [15:0] rms;
        logic        [15:0] p2p;
        logic signed [15:0] dc;
        logic        [12:0] clips;
        logic               ok;
        logic        [15:0] freq;
        logic signed [15:0] pf;
        logic        [15:0] thd;
    } window_t;

    logic clk, rst_n;
    logic psel, penable, pwrite, pready;
    logic [3:0] paddr;
    logic [31:0] pwdata, prdata;
    logic in_valid, in_stall, out_valid, out_stall;
    logic signed [15:0] phase_a_volts, phase_b_volts, phase_c_volts, power_factor_in;
    logic [15:0] line_frequency, distortion_percent;
    logic last_sample;
    logic [15:0] rms_volts, peak_to_peak, mean_frequency, mean_distortion;
    logic signed [15:0] dc_mean, mean_power_factor;
    logic [12:0] clipped_count;
    logic compliant;

    waveform_window_statistics_top uut (.*);

    // Shadow copy of the register file.
    logic [1:0]  sh_phase;
    logic [14:0] sh_clip, sh_low, sh_high;

    // Running window totals of the predictor.
    longint unsigned acc_sq, acc_freq, acc_thd;
    longint          acc_lvl, acc_pf;
    int              win_lo, win_hi, acc_clips, acc_n;

    beat_t   sample_q[$];
    window_t window_q[$];
    beat_t   cur_beat;

    int  errors;
    int  gap_left, out_wait;
    bit  no_gaps;
    bit  hold_out;
    bit  pressure_go;
    int  idle_cycles;

    // Clock and the single reset pulse.
    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial begin
        rst_n = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1;
    end

    task automatic note_mismatch(input string what, input longint got, input longint want);
        errors++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    function automatic longint unsigned floor_root(input longint unsigned x);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= root + bitv) begin
                x -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic void clear_totals();
        acc_sq = 0; acc_lvl = 0; win_lo = 0; win_hi = 0; acc_clips = 0;
        acc_n = 0; acc_freq = 0; acc_pf = 0; acc_thd = 0;
    endfunction

    // Fold one accepted beat into the window; on close, queue the expected result.
    function automatic void fold_sample(input beat_t b);
        int v, mag;
        longint unsigned rt;
        window_t w;
        case (sh_phase)
            PhaseA:  v = b.va;
            PhaseB:  v = b.vb;
            default: v = b.vc;   // unused code 3 also picks C
        endcase
        if (acc_n == 0) begin
            win_lo = v;
            win_hi = v;
        end else begin
            if (v < win_lo) win_lo = v;
            if (v > win_hi) win_hi = v;
        end
        acc_sq  += longint'(v) * longint'(v);
        acc_lvl += v;
        mag = v < 0 ? -v : v;
        if (mag >= int'(sh_clip)) acc_clips++;
        acc_freq += b.freq;
        acc_pf   += b.pf;
        acc_thd  += b.thd;
        acc_n++;
        if (!b.last && acc_n < MaxSamples) return;
        rt      = floor_root(acc_sq / longint'(acc_n));
        w.rms   = rt[15:0];
        w.p2p   = 16'(win_hi - win_lo);
        w.dc    = 16'(acc_lvl / longint'(acc_n));   // truncates toward zero
        w.clips = 13'(acc_clips);
        w.ok    = (rt >= sh_low) && (rt <= sh_high);
        w.freq  = 16'(acc_freq / longint'(acc_n));
        w.pf    = 16'(acc_pf / longint'(acc_n));
        w.thd   = 16'(acc_thd / longint'(acc_n));
        window_q.push_back(w);
        clear_totals();
    endfunction

    // Input driver: one beat in flight, per-beat gap drawn 0..9 unless no_gaps is set.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 0;
            gap_left <= 0;
            phase_a_volts <= 0; phase_b_volts <= 0; phase_c_volts <= 0;
            line_frequency <= 0; power_factor_in <= 0; distortion_percent <= 0;
            last_sample <= 0;
        end else if (!in_valid || !in_stall) begin
            if (in_valid) fold_sample(cur_beat);
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                in_valid <= 0;
            end else if (sample_q.size() > 0) begin
                cur_beat = sample_q.pop_front();
                phase_a_volts      <= cur_beat.va;
                phase_b_volts      <= cur_beat.vb;
                phase_c_volts      <= cur_beat.vc;
                line_frequency     <= cur_beat.freq;
                power_factor_in    <= cur_beat.pf;
                distortion_percent <= cur_beat.thd;
                last_sample        <= cur_beat.last;
                in_valid           <= 1;
                gap_left           <= no_gaps ? 0 : $urandom_range(0, 9);
            end else begin
                in_valid <= 0;
            end
        end
    end

    // Output monitor: checks each accepted result beat against the oldest expectation.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_stall <= 0;
            out_wait  <= 0;
        end else begin
            if (out_valid && !out_stall) begin
                if (window_q.size() == 0) begin
                    errors++;
                    $display("unexpected result beat at %0t", $realtime);
                end else begin
                    window_t w;
                    w = window_q.pop_front();
                    if (rms_volts !== w.rms) note_mismatch("rms_volts", rms_volts, w.rms);
                    if (peak_to_peak !== w.p2p) note_mismatch("peak_to_peak", peak_to_peak, w.p2p);
                    if (dc_mean !== w.dc) note_mismatch("dc_mean", dc_mean, w.dc);
                    if (clipped_count !== w.clips)
                        note_mismatch("clipped_count", clipped_count, w.clips);
                    if (compliant !== w.ok) note_mismatch("compliant", compliant, w.ok);
                    if (mean_frequency !== w.freq)
                        note_mismatch("mean_frequency", mean_frequency, w.freq);
                    if (mean_power_factor !== w.pf)
                        note_mismatch("mean_power_factor", mean_power_factor, w.pf);
                    if (mean_distortion !== w.thd)
                        note_mismatch("mean_distortion", mean_distortion, w.thd);
                end
                out_wait  <= no_gaps ? 0 : $urandom_range(0, 9);
                out_stall <= hold_out;
            end else begin
                if (out_wait > 0) out_wait <= out_wait - 1;
                out_stall <= hold_out || (out_wait > 1);
            end
        end
    end

    // Long receiver hold-off so a second close backs up into the input.
    initial begin
        hold_out = 0;
        wait (pressure_go);
        @(posedge clk);
        hold_out <= 1;
        repeat (HoldCycles) @(posedge clk);
        hold_out <= 0;
    end

    // Watchdog: trips when neither channel moves for too long.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= StallLimit) begin
            $display("watchdog: no progress for %0d cycles", StallLimit);
            $display("tb_waveform_window_statistics_top: FAIL");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        @(posedge clk);
        psel    <= 1;
        pwrite  <= 1;
        penable <= 0;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel    <= 0;
        penable <= 0;
        pwrite  <= 0;
        case (idx)
            RegPhase:  sh_phase = val[1:0];
            RegClip:   sh_clip  = val[14:0];
            RegRmsLow: sh_low   = val[14:0];
            default:   sh_high  = val[14:0];
        endcase
    endtask

    function automatic beat_t rand_beat(input bit last);
        beat_t b;
        b.va   = 16'($urandom);
        b.vb   = 16'($urandom);
        b.vc   = 16'($urandom);
        b.freq = 16'($urandom);
        b.pf   = 16'($urandom_range(0, 32768) - 16384);
        b.thd  = 16'($urandom);
        b.last = last;
        // sometimes keep voltages near mains level so limits matter
        if ($urandom_range(0, 2) == 0) begin
            b.va = 16'($urandom_range(0, 40000) - 20000);
            b.vb = 16'($urandom_range(0, 40000) - 20000);
            b.vc = 16'($urandom_range(0, 40000) - 20000);
        end
        return b;
    endfunction

    function automatic void queue_window(input int len);
        for (int i = 0; i < len; i++) sample_q.push_back(rand_beat(i == len - 1));
    endfunction

    function automatic beat_t flat_beat(input int v, input int f, input int p, input int t,
                                        input bit last);
        beat_t b;
        b.va = 16'(v); b.vb = 16'(v); b.vc = 16'(v);
        b.freq = 16'(f); b.pf = 16'(p); b.thd = 16'(t); b.last = last;
        return b;
    endfunction

    // Wait for every queued beat and result, then let the close pipeline settle.
    task automatic drain();
        wait (sample_q.size() == 0 && !in_valid && window_q.size() == 0);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic set_regs(input logic [1:0] ph, input int clip, input int lo, input int hi);
        reg_write(RegPhase, ph);
        reg_write(RegClip, clip);
        reg_write(RegRmsLow, lo);
        reg_write(RegRmsHi, hi);
    endtask

    initial begin
        beat_t b;
        errors = 0; no_gaps = 0; pressure_go = 0; idle_cycles = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        sh_phase = 2'd0; sh_clip = 15'd20794; sh_low = 15'd13248; sh_high = 15'd16192;
        clear_totals();
        wait (rst_n);
        @(posedge clk);

        // Directed: field extremes under reset settings.
        sample_q.push_back(flat_beat(-32768, 0, -16384, 0, 1));       // one-sample window
        sample_q.push_back(flat_beat(32767, 65535, 16384, 65535, 1));
        sample_q.push_back(flat_beat(-32768, 65535, -16384, 65535, 0));
        sample_q.push_back(flat_beat(32767, 0, 16384, 0, 1));         // full swing p2p
        sample_q.push_back(flat_beat(14000, 15360, 16000, 512, 0));   // compliant window
        sample_q.push_back(flat_beat(-14000, 15360, 15000, 700, 1));
        sample_q.push_back(flat_beat(-3, 1, -3, 1, 0));               // negative mean
        sample_q.push_back(flat_beat(1, 1, 1, 2, 1));
        drain();

        // Directed: each phase code, the unused one included, with distinct phases.
        for (int ph = 0; ph < 4; ph++) begin
            reg_write(RegPhase, ph);
            b = flat_beat(0, 15360, 8000, 100, 0);
            b.va = 16'sd1000; b.vb = -16'sd2000; b.vc = 16'sd30000;
            sample_q.push_back(b);
            b.va = -16'sd500; b.vb = 16'sd2500; b.vc = -16'sd21000; b.last = 1;
            sample_q.push_back(b);
            drain();
        end

        // Directed: zero clip level, crossed limits, widest limits.
        set_regs(2'd0, 0, 16192, 13248);
        sample_q.push_back(flat_beat(0, 100, 0, 0, 0));
        sample_q.push_back(flat_beat(14000, 100, 0, 0, 1));
        drain();
        set_regs(2'd1, 32767, 0, 32767);
        sample_q.push_back(flat_beat(-32768, 100, 0, 0, 0));
        sample_q.push_back(flat_beat(32767, 100, 0, 0, 1));
        drain();

        // Forced close: a full window with no last marker, every sample clipped.
        set_regs(2'd2, 0, 0, 32767);
        no_gaps = 1;
        for (int i = 0; i < MaxSamples; i++) sample_q.push_back(rand_beat(0));
        queue_window(3);
        drain();
        no_gaps = 0;

        // Random phases across several register settings.
        for (int phs = 0; phs < 6; phs++) begin
            case (phs)
                0: set_regs(2'd0, 20794, 13248, 16192);
                1: set_regs(2'd3, 32767, 0, 32767);
                2: set_regs(2'd1, 0, 32767, 0);
                default: set_regs(2'($urandom_range(0, 3)), $urandom_range(0, 32767),
                                  $urandom_range(0, 32767), $urandom_range(0, 32767));
            endcase
            no_gaps = (phs == 1);
            if (phs == 4) pressure_go = 1;
            for (int n = 0; n < 100; ) begin
                int len;
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
                queue_window(len);
                n += len;
            end
            drain();
        end

        if (errors == 0)
            $display("tb_waveform_window_statistics_top: PASS");
        else
            $display("tb_waveform_window_statistics_top: FAIL");
        $finish;
    end

endmodule

@@ waveform_window_statistics_top.f @@
+incdir+hw/rtl
hw/rtl/wws_pkg.sv
hw/rtl/wws_ctrl.sv
hw/rtl/wws_datapath.sv
hw/rtl/waveform_window_statistics_top.sv
tb/tb_waveform_window_statistics_top.sv
